// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the natural log datapath.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define FLN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define FLN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/fln_pkg.sv
// ---------------------------------------------------------------------------
// fln_pkg
// Types, constants and helpers for the single-precision natural log pipe.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fln_pkg;

  localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
  localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;
  localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;
  localparam logic [7:0]  UNIT_EXP     = 8'd127;
  localparam logic [7:0]  HALF_EXP     = 8'd126;
  localparam logic [7:0]  EXP_MAX      = 8'hFF;

  localparam int UP_LEN = 10;
  localparam int DN_LEN = 8;
  localparam int STEPS  = UP_LEN - 1;

  typedef logic signed [11:0] fln_exp_t;
  // exponent given to a zero operand so it lands on the small side of any nonzero one
  localparam fln_exp_t ZERO_E = -12'sd1024;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_bits;
    logic        up;
    logic [31:0] r;
    logic        ksign;
    logic        kzero;
    fln_exp_t    kexp;
    logic [52:0] kmant;
  } fln_side_t;

  // double bit pattern to single, round to nearest even, normal range only
  function automatic logic [31:0] dbl_to_sgl(input logic [63:0] d);
    logic [7:0]  se;
    logic        rnd;
    logic [30:0] body;
    se   = 8'(d[62:52] - 11'd896);
    rnd  = d[28] & ((|d[27:0]) | d[29]);
    body = {se, d[51:29]} + 31'(rnd);
    return {d[63], body};
  endfunction

  // leading zero count, 64 when the word is zero
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  localparam logic [63:0] LN2_BITS = $realtobits(0.693147180559945309417232121458176568);
  localparam logic [52:0] LN2_MANT = {1'b1, LN2_BITS[51:0]};

  // ln(1+r) on [0,1), highest degree first
  localparam logic [31:0] UP_C [UP_LEN] = '{
    dbl_to_sgl($realtobits(-0.0032440251717337546)),
    dbl_to_sgl($realtobits(0.019851462335085494)),
    dbl_to_sgl($realtobits(-0.056959534201723228)),
    dbl_to_sgl($realtobits(0.10603654877058005)),
    dbl_to_sgl($realtobits(-0.15305592566389509)),
    dbl_to_sgl($realtobits(0.19675939255501274)),
    dbl_to_sgl($realtobits(-0.24954133655537836)),
    dbl_to_sgl($realtobits(0.33329962416588654)),
    dbl_to_sgl($realtobits(-0.49999902422775899)),
    dbl_to_sgl($realtobits(0.99999999528721917))
  };

  // ln(1+r) on [-0.5,0), highest degree first
  localparam logic [31:0] DN_C [DN_LEN] = '{
    dbl_to_sgl($realtobits(-1.1849314839059311)),
    dbl_to_sgl($realtobits(-1.0815401875157433)),
    dbl_to_sgl($realtobits(-0.78543102733181391)),
    dbl_to_sgl($realtobits(0.038018061198611182)),
    dbl_to_sgl($realtobits(-0.27225053856081005)),
    dbl_to_sgl($realtobits(0.33186261984516702)),
    dbl_to_sgl($realtobits(-0.50003654322887447)),
    dbl_to_sgl($realtobits(0.99999985242729561))
  };

endpackage

// File: hw/rtl/fln_fma.sv
// ---------------------------------------------------------------------------
// fln_fma
// Six-stage single-precision fused multiply-add, a*b + c, one rounding
// (nearest even). Operands are normal or zero. Side data rides along.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fln_fma (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  input  logic [31:0]        c,
  input  fln_pkg::fln_side_t side_in,
  output logic               out_valid,
  output logic [31:0]        res,
  output fln_pkg::fln_side_t side_out
);
  import fln_pkg::*;

  localparam int DEPTH = 6;

  logic [DEPTH-1:0] v_r;
  fln_side_t        side_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < DEPTH; i++) side_r[i] <= side_r[i-1];
    end
  end

  // stage 1: decode, multiply
  logic        a_zero, b_zero, c_zero;
  logic [23:0] ma, mb;
  logic [47:0] p1_nxt, p1_r;
  fln_exp_t    esum_nxt, esum1_r, ec_nxt, ec1_r;
  logic [23:0] mc_nxt, mc1_r;
  logic        sp1_r, pz1_r, sc1_r;

  always_comb begin
    a_zero   = (a[30:23] == 8'h00);
    b_zero   = (b[30:23] == 8'h00);
    c_zero   = (c[30:23] == 8'h00);
    ma       = a_zero ? 24'h0 : {1'b1, a[22:0]};
    mb       = b_zero ? 24'h0 : {1'b1, b[22:0]};
    p1_nxt   = ma * mb;
    esum_nxt = $signed({4'b0, a[30:23]}) + $signed({4'b0, b[30:23]}) - 12'sd254;
    ec_nxt   = c_zero ? ZERO_E : $signed({4'b0, c[30:23]}) - 12'sd127;
    mc_nxt   = c_zero ? 24'h0 : {1'b1, c[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p1_nxt;
      esum1_r <= esum_nxt;
      ec1_r   <= ec_nxt;
      mc1_r   <= mc_nxt;
      sp1_r   <= a[31] ^ b[31];
      pz1_r   <= a_zero | b_zero;
      sc1_r   <= c[31];
    end
  end

  // stage 2: swap and align the smaller operand, sticky in the lsb
  logic [47:0] mp, mcw, mbig, msml;
  fln_exp_t    ep, ebig, esml, ediff;
  logic        pbig;
  logic [5:0]  dsh;
  logic [51:0] wide, shifted, lost;
  logic [51:0] big2_nxt, sml2_nxt, big2_r, sml2_r;
  logic        sbig2_r, ssml2_r, sub2_r;
  fln_exp_t    ebig2_r;

  always_comb begin
    mp   = pz1_r ? 48'h0 : (p1_r[47] ? p1_r : {p1_r[46:0], 1'b0});
    ep   = pz1_r ? ZERO_E : (p1_r[47] ? esum1_r + 12'sd1 : esum1_r);
    mcw  = {mc1_r, 24'h0};
    pbig = (ep >= ec1_r);
    mbig = pbig ? mp : mcw;
    msml = pbig ? mcw : mp;
    ebig = pbig ? ep : ec1_r;
    esml = pbig ? ec1_r : ep;
    ediff = ebig - esml;
    dsh  = (ediff > 12'sd63) ? 6'd63 : ediff[5:0];
    wide = {msml, 4'h0};
    shifted  = wide >> dsh;
    lost     = wide & ~({52{1'b1}} << dsh);
    sml2_nxt = {shifted[51:1], shifted[0] | (|lost)};
    big2_nxt = {mbig, 4'h0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big2_r  <= big2_nxt;
      sml2_r  <= sml2_nxt;
      ebig2_r <= ebig;
      sbig2_r <= pbig ? sp1_r : sc1_r;
      ssml2_r <= pbig ? sc1_r : sp1_r;
      sub2_r  <= sp1_r ^ sc1_r;
    end
  end

  // stage 3: add or subtract magnitudes
  logic [52:0] diff, s3_nxt, s3_r;
  logic        sign3_nxt, sign3_r, zero3_r;
  fln_exp_t    ebig3_r;

  always_comb begin
    diff = {1'b0, big2_r} - {1'b0, sml2_r};
    if (sub2_r) begin
      s3_nxt    = diff[52] ? (53'h0 - diff) : diff;
      sign3_nxt = diff[52] ? ssml2_r : sbig2_r;
    end else begin
      s3_nxt    = {1'b0, big2_r} + {1'b0, sml2_r};
      sign3_nxt = sbig2_r;
    end
    // exact zero of opposite signs is plus zero
    if (s3_nxt == 53'h0) sign3_nxt = sub2_r ? 1'b0 : sbig2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r    <= s3_nxt;
      sign3_r <= sign3_nxt;
      zero3_r <= (s3_nxt == 53'h0);
      ebig3_r <= ebig2_r;
    end
  end

  // stage 4: leading zero count
  logic [6:0]  lz_full;
  logic [5:0]  lz4_r;
  logic [52:0] s4_r;
  logic        sign4_r, zero4_r;
  fln_exp_t    ebig4_r;

  assign lz_full = lzc64({s3_r, 11'h0});

  always_ff @(posedge clk) begin
    if (en) begin
      lz4_r   <= lz_full[5:0];
      s4_r    <= s3_r;
      sign4_r <= sign3_r;
      zero4_r <= zero3_r;
      ebig4_r <= ebig3_r;
    end
  end

  // stage 5: normalize
  logic [52:0] n5_r;
  fln_exp_t    e5_r;
  logic        sign5_r, zero5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n5_r    <= s4_r << lz4_r;
      e5_r    <= ebig4_r + 12'sd1 - $signed({6'b0, lz4_r});
      sign5_r <= sign4_r;
      zero5_r <= zero4_r;
    end
  end

  // stage 6: round to nearest even
  logic        rnd6;
  fln_exp_t    bexp6;
  logic [31:0] res_nxt, res_r;

  always_comb begin
    rnd6  = n5_r[28] & ((|n5_r[27:0]) | n5_r[29]);
    bexp6 = e5_r + 12'sd127;
    res_nxt = zero5_r ? {sign5_r, 31'h0}
                      : {sign5_r, {bexp6[7:0], n5_r[51:29]} + 31'(rnd6)};
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign out_valid = v_r[DEPTH-1];
  assign res       = res_r;
  assign side_out  = side_r[DEPTH-1];

endmodule

// File: hw/rtl/fln_sum.sv
// ---------------------------------------------------------------------------
// fln_sum
// Six-stage final add: scale term (double) plus ln(1+r) (single), rounded
// to double and then to single, with the special-case word selected last.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fln_sum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        ln1p,
  input  fln_pkg::fln_side_t side_in,
  output logic               out_valid,
  output logic [31:0]        res
);
  import fln_pkg::*;

  localparam int DEPTH = 6;

  logic [DEPTH-1:0] v_r;
  logic             spec_r [DEPTH-1];
  logic [31:0]      spec_bits_r [DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec_r[0]      <= side_in.spec;
      spec_bits_r[0] <= side_in.spec_bits;
      for (int i = 1; i < DEPTH - 1; i++) begin
        spec_r[i]      <= spec_r[i-1];
        spec_bits_r[i] <= spec_bits_r[i-1];
      end
    end
  end

  // stage 1: decode, swap, align
  logic        l_zero, kbig;
  logic [52:0] ml, mk, mbig, msml;
  fln_exp_t    el, ek, ebig, esml, ediff;
  logic [5:0]  dsh;
  logic [56:0] wide, shifted, lost;
  logic [56:0] big1_r, sml1_r;
  logic        sbig1_r, ssml1_r, sub1_r;
  fln_exp_t    ebig1_r;

  always_comb begin
    l_zero = (ln1p[30:23] == 8'h00);
    ml   = l_zero ? 53'h0 : {1'b1, ln1p[22:0], 29'h0};
    el   = l_zero ? ZERO_E : $signed({4'b0, ln1p[30:23]}) - 12'sd127;
    mk   = side_in.kzero ? 53'h0 : side_in.kmant;
    ek   = side_in.kzero ? ZERO_E : side_in.kexp;
    kbig = (ek >= el);
    mbig = kbig ? mk : ml;
    msml = kbig ? ml : mk;
    ebig = kbig ? ek : el;
    esml = kbig ? el : ek;
    ediff = ebig - esml;
    dsh  = (ediff > 12'sd63) ? 6'd63 : ediff[5:0];
    wide = {msml, 4'h0};
    shifted = wide >> dsh;
    lost    = wide & ~({57{1'b1}} << dsh);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big1_r  <= {mbig, 4'h0};
      sml1_r  <= {shifted[56:1], shifted[0] | (|lost)};
      ebig1_r <= ebig;
      sbig1_r <= kbig ? side_in.ksign : ln1p[31];
      ssml1_r <= kbig ? ln1p[31] : side_in.ksign;
      sub1_r  <= side_in.ksign ^ ln1p[31];
    end
  end

  // stage 2: add or subtract
  logic [57:0] diff, s2_nxt, s2_r;
  logic        sign2_nxt, sign2_r, zero2_r;
  fln_exp_t    ebig2_r;

  always_comb begin
    diff = {1'b0, big1_r} - {1'b0, sml1_r};
    if (sub1_r) begin
      s2_nxt    = diff[57] ? (58'h0 - diff) : diff;
      sign2_nxt = diff[57] ? ssml1_r : sbig1_r;
    end else begin
      s2_nxt    = {1'b0, big1_r} + {1'b0, sml1_r};
      sign2_nxt = sbig1_r;
    end
    if (s2_nxt == 58'h0) sign2_nxt = sub1_r ? 1'b0 : sbig1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r    <= s2_nxt;
      sign2_r <= sign2_nxt;
      zero2_r <= (s2_nxt == 58'h0);
      ebig2_r <= ebig1_r;
    end
  end

  // stage 3: leading zero count
  logic [6:0]  lz_full;
  logic [5:0]  lz3_r;
  logic [57:0] s3_r;
  logic        sign3_r, zero3_r;
  fln_exp_t    ebig3_r;

  assign lz_full = lzc64({s2_r, 6'h0});

  always_ff @(posedge clk) begin
    if (en) begin
      lz3_r   <= lz_full[5:0];
      s3_r    <= s2_r;
      sign3_r <= sign2_r;
      zero3_r <= zero2_r;
      ebig3_r <= ebig2_r;
    end
  end

  // stage 4: normalize
  logic [57:0] n4_r;
  fln_exp_t    e4_r;
  logic        sign4_r, zero4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n4_r    <= s3_r << lz3_r;
      e4_r    <= ebig3_r + 12'sd1 - $signed({6'b0, lz3_r});
      sign4_r <= sign3_r;
      zero4_r <= zero3_r;
    end
  end

  // stage 5: round to double
  logic        rnd5;
  logic [53:0] m54;
  logic [52:0] m5_r;
  fln_exp_t    e5_r;
  logic        sign5_r, zero5_r;

  always_comb begin
    rnd5 = n4_r[4] & ((|n4_r[3:0]) | n4_r[5]);
    m54  = {1'b0, n4_r[57:5]} + 54'(rnd5);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_r    <= m54[53] ? m54[53:1] : m54[52:0];
      e5_r    <= m54[53] ? e4_r + 12'sd1 : e4_r;
      sign5_r <= sign4_r;
      zero5_r <= zero4_r;
    end
  end

  // stage 6: round double to single, then the special word wins
  logic        rnd6;
  fln_exp_t    bexp6;
  logic [31:0] res_nxt, res_r;

  always_comb begin
    rnd6  = m5_r[28] & ((|m5_r[27:0]) | m5_r[29]);
    bexp6 = e5_r + 12'sd127;
    if (spec_r[DEPTH-2]) begin
      res_nxt = spec_bits_r[DEPTH-2];
    end else if (zero5_r) begin
      res_nxt = {sign5_r, 31'h0};
    end else begin
      res_nxt = {sign5_r, {bexp6[7:0], m5_r[51:29]} + 31'(rnd6)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign out_valid = v_r[DEPTH-1];
  assign res       = res_r;

endmodule

// File: hw/rtl/float_natural_log.sv
// ---------------------------------------------------------------------------
// float_natural_log
// Natural logarithm of an IEEE single-precision word, fully pipelined.
//
//   channel | dir | ports                               | word
//   in_     | in  | in_tvalid, in_tready, in_tdata[31:0] | x_bits
//   out_    | out | out_tvalid, out_tready, out_tdata    | log_bits
//
// One word per cycle while the output word is taken; the path is: input register,
// reduction, three scale-term stages, ten fused multiply-add units of six
// stages each (nine Horner steps and the final r*q), six-stage final add.
// Reset clears the valid bits only; no clearing pass.
// When the output word is not taken the whole pipe holds in place.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module float_natural_log (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] x_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] log_bits
);
  import fln_pkg::*;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && rst_n;

  // stage A: input register
  logic        va_r;
  logic [31:0] x_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) x_a_r <= in_tdata;
  end

  // stage B: classify, reduce mantissa to r, start the scale product
  logic [7:0]        be;
  logic [22:0]       mant;
  logic              up;
  logic [23:0]       v, vn;
  logic [6:0]        rlz_full;
  logic [4:0]        rlz;
  logic [7:0]        r_exp;
  logic signed [9:0] kn_int;
  logic [7:0]        nmag;
  fln_side_t         side_b_nxt, side_b_r;
  logic [60:0]       kprod_nxt, kprod_b_r;
  logic              vb_r;

  always_comb begin
    be       = x_a_r[30:23];
    mant     = x_a_r[22:0];
    up       = (be == UNIT_EXP);
    v        = up ? {1'b0, mant} : (24'h80_0000 - {1'b0, mant});
    rlz_full = lzc64({v, 40'h0});
    rlz      = rlz_full[4:0];
    vn       = v << rlz;
    r_exp    = up ? (UNIT_EXP - {3'b0, rlz}) : (HALF_EXP - {3'b0, rlz});
    kn_int   = $signed({2'b00, be}) - 10'sd126;
    nmag     = kn_int[9] ? 8'(-kn_int) : 8'(kn_int);
    kprod_nxt = 61'(nmag) * 61'(LN2_MANT);

    side_b_nxt       = '0;
    side_b_nxt.up    = up;
    side_b_nxt.r     = (up && mant == 23'h0) ? 32'h0 : {!up, r_exp, vn[22:0]};
    side_b_nxt.ksign = kn_int[9];
    side_b_nxt.kzero = up || (kn_int == 10'sd0);
    if (be == EXP_MAX && mant != 23'h0) begin
      side_b_nxt.spec      = 1'b1;
      side_b_nxt.spec_bits = x_a_r;
    end else if (x_a_r[31] && x_a_r[30:0] != 31'h0) begin
      side_b_nxt.spec      = 1'b1;
      side_b_nxt.spec_bits = QNAN_BITS;
    end else if (be == 8'h00) begin
      side_b_nxt.spec      = 1'b1;
      side_b_nxt.spec_bits = NEG_INF_BITS;
    end else if (be == EXP_MAX) begin
      side_b_nxt.spec      = 1'b1;
      side_b_nxt.spec_bits = POS_INF_BITS;
    end
  end

  // stages C, D, E: normalize and round (e+1)*ln2 to double
  logic        vc_r, vd_r, ve_r;
  fln_side_t   side_c_r, side_d_r, side_e_r;
  logic [60:0] kprod_c_r, kn_d_r;
  logic [6:0]  klz_full;
  logic [5:0]  klz_c_r;
  fln_exp_t    kexp_d_r;
  logic        krnd;
  logic [53:0] km54;
  fln_side_t   side_e_nxt;

  assign klz_full = lzc64({kprod_b_r, 3'h0});

  always_comb begin
    krnd = kn_d_r[7] & ((|kn_d_r[6:0]) | kn_d_r[8]);
    km54 = {1'b0, kn_d_r[60:8]} + 54'(krnd);
    side_e_nxt       = side_d_r;
    side_e_nxt.kmant = km54[53] ? km54[53:1] : km54[52:0];
    side_e_nxt.kexp  = km54[53] ? kexp_d_r + 12'sd1 : kexp_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_b_r  <= side_b_nxt;
      kprod_b_r <= kprod_nxt;
      side_c_r  <= side_b_r;
      kprod_c_r <= kprod_b_r;
      klz_c_r   <= klz_full[5:0];
      side_d_r  <= side_c_r;
      kn_d_r    <= kprod_c_r << klz_c_r;
      kexp_d_r  <= 12'sd7 - $signed({6'b0, klz_c_r});
      side_e_r  <= side_e_nxt;
    end
  end

  // Horner chain: step s computes r*q + coef; the short chain idles its
  // last steps as 0*q + q
  fln_side_t   sd [STEPS+2];
  logic        vq [STEPS+2];
  logic [31:0] q  [STEPS+1];

  assign sd[0] = side_e_r;
  assign vq[0] = ve_r;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [31:0] a_s, b_s, c_s;
    if (s == 0) begin : g_first
      assign a_s = sd[s].r;
      assign b_s = sd[s].up ? UP_C[0] : DN_C[0];
      assign c_s = sd[s].up ? UP_C[1] : DN_C[1];
    end else if (s < DN_LEN - 1) begin : g_mid
      assign a_s = sd[s].r;
      assign b_s = q[s-1];
      assign c_s = sd[s].up ? UP_C[s+1] : DN_C[s+1];
    end else begin : g_tail
      assign a_s = sd[s].up ? sd[s].r : 32'h0;
      assign b_s = q[s-1];
      assign c_s = sd[s].up ? UP_C[s+1] : q[s-1];
    end

    fln_fma u_fma (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (vq[s]),
      .a        (a_s),
      .b        (b_s),
      .c        (c_s),
      .side_in  (sd[s]),
      .out_valid(vq[s+1]),
      .res      (q[s]),
      .side_out (sd[s+1])
    );
  end

  // ln(1+r) = r*q
  fln_fma u_fma_last (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (vq[STEPS]),
    .a        (sd[STEPS].r),
    .b        (q[STEPS-1]),
    .c        (32'h0),
    .side_in  (sd[STEPS]),
    .out_valid(vq[STEPS+1]),
    .res      (q[STEPS]),
    .side_out (sd[STEPS+1])
  );

  fln_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (vq[STEPS+1]),
    .ln1p     (q[STEPS]),
    .side_in  (sd[STEPS+1]),
    .out_valid(out_tvalid),
    .res      (out_tdata)
  );

  `FLN_ASSERT_NXT(a_word_moves, va_r && in_tready, vb_r, "word lost after input register")
  `FLN_ASSERT_IMP(a_k_norm, ve_r && !side_e_r.kzero, side_e_r.kmant[52], "scale term not normalized")
  `FLN_ASSERT_IMP(a_r_nonzero, vb_r && !side_b_r.spec && !side_b_r.up, side_b_r.r[30:23] != 8'h00, "reduced operand zero")

endmodule
